### hdl/pbs_pkg.sv
// Shared types and constants for the nth byte pattern search block.
package pbs_pkg;

   localparam int BYTE_W        = 8;
   localparam int ADDR_W        = 64;
   localparam int PATTERN_W     = 64;
   localparam int PATTERN_BYTES = PATTERN_W / BYTE_W;
   localparam int LEN_W         = 4;
   localparam int OCC_W         = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;

   localparam int MAX_PATTERN_BYTES_DEFAULT = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES    = 2'd0,
      CSR_PATTERN_LENGTH   = 2'd1,
      CSR_OCCURRENCE_INDEX = 2'd2,
      CSR_BASE_ADDRESS     = 2'd3
   } csr_index_type;

   // Per-cycle control shared by every cell of the window
   typedef struct packed {
      logic shift;
      logic clear;
   } pbs_cell_ctrl_type;

endpackage

### hdl/pbs_cell.sv
// One window cell: holds a byte and its valid bit, compares the incoming byte.
module pbs_cell
   import pbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pbs_cell_ctrl_type ctrl,
   input  logic [BYTE_W-1:0] byte_in,
   input  logic              valid_in,
   input  logic [BYTE_W-1:0] want,
   output logic [BYTE_W-1:0] byte_out,
   output logic              valid_out,
   output logic              hit
);

   logic [BYTE_W-1:0] data_ff;
   logic              valid_ff;
   logic              valid_next_in;

   // The byte arriving now is what this cell holds after the shift
   assign hit = valid_in && (byte_in == want);

   always_comb begin
      valid_next_in = valid_ff;
      if (ctrl.clear) begin
         valid_next_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_next_in = valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_next_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= byte_in;
      end
   end

   assign byte_out  = data_ff;
   assign valid_out = valid_ff;

endmodule

### hdl/nth_byte_pattern_search_top.sv
// Top level of the nth byte pattern search: cell chain, match control, output skid.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata[7:0] data_byte, tlast last_byte
//  rsp     | out | rsp_tvalid/tready  | tdata[63:0] match_address, tuser found
//  csr     | in  | csr_valid/ready    | csr_index register, csr_data value
//
// One byte per cycle while req_tready is high: each byte is compared in the cycle
// it is taken, across all window cells in parallel, and the result is registered.
// Reset is synchronous and clears the window, counters and output queue.
// A two-entry output queue lets bytes keep flowing while a result waits;
// req_tready drops only when both entries are full.
module nth_byte_pattern_search_top
   import pbs_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,    // [7:0] data_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ADDR_W-1:0]      rsp_tdata,    // [63:0] match_address
   output logic                   rsp_tuser,    // [0] found
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers
   logic [PATTERN_W-1:0] pattern_ff;
   logic [LEN_W-1:0]     length_ff;
   logic [OCC_W-1:0]     occ_ff;
   logic [ADDR_W-1:0]    base_ff;

   // Search state
   logic [ADDR_W-1:0]    offset_ff, offset_in;
   logic [ADDR_W-1:0]    cur_addr_ff, cur_addr_in;   // base + offset
   logic [OCC_W-1:0]     count_ff, count_in;
   logic                 done_ff, done_in;

   // Output queue
   logic                 out_valid_ff, out_valid_in;
   logic                 out_found_ff, out_found_in;
   logic [ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic                 skid_found_ff, skid_found_in;
   logic [ADDR_W-1:0]    skid_addr_ff, skid_addr_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 csr_fire;
   logic [LEN_W-1:0]     len_used;
   logic [BYTE_W-1:0]    pat_byte [PATTERN_BYTES];
   pbs_cell_ctrl_type    cell_ctrl;
   logic [BYTE_W-1:0]    chain_byte  [MAX_PATTERN_BYTES+1];
   logic                 chain_valid [MAX_PATTERN_BYTES+1];
   logic [MAX_PATTERN_BYTES-1:0] hit;
   logic                 window_match;
   logic                 res_valid;
   logic                 res_found;
   logic [ADDR_W-1:0]    res_addr;
   logic                 restart;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;

   // Clamp the pattern length into 1..MAX_PATTERN_BYTES
   always_comb begin
      len_used = length_ff;
      if (length_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (length_ff > LEN_W'(MAX_PATTERN_BYTES)) begin
         len_used = LEN_W'(MAX_PATTERN_BYTES);
      end
   end

   always_comb begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         pat_byte[k] = pattern_ff[k*BYTE_W +: BYTE_W];
      end
   end

   // Cell chain: cell 0 takes the new byte, each cell hands its byte onwards
   assign chain_byte[0]  = req_tdata;
   assign chain_valid[0] = 1'b1;

   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      logic [LEN_W-1:0] sel;
      // Newest byte lines up with the last pattern byte
      assign sel = len_used - LEN_W'(i) - LEN_W'(1);

      pbs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .byte_in   (chain_byte[i]),
         .valid_in  (chain_valid[i]),
         .want      (pat_byte[sel[$clog2(PATTERN_BYTES)-1:0]]),
         .byte_out  (chain_byte[i+1]),
         .valid_out (chain_valid[i+1]),
         .hit       (hit[i])
      );
   end

   always_comb begin
      window_match = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (LEN_W'(i) < len_used) begin
            window_match = window_match && hit[i];
         end
      end
   end

   // Per-byte search step
   always_comb begin
      offset_in   = offset_ff;
      cur_addr_in = cur_addr_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      res_valid   = 1'b0;
      res_found   = 1'b0;
      res_addr    = '0;
      restart     = 1'b0;
      cell_ctrl   = '0;

      if (req_fire) begin
         if (done_ff) begin
            restart = req_tlast;
         end else begin
            cell_ctrl.shift = 1'b1;
            if (window_match) begin
               if (count_ff == occ_ff) begin
                  res_valid = 1'b1;
                  res_found = 1'b1;
                  res_addr  = cur_addr_ff - ADDR_W'(len_used - LEN_W'(1));
                  done_in   = 1'b1;
               end else if (count_ff != {OCC_W{1'b1}}) begin
                  count_in = count_ff + OCC_W'(1);
               end
            end
            offset_in   = offset_ff + ADDR_W'(1);
            cur_addr_in = cur_addr_ff + ADDR_W'(1);
            if (req_tlast) begin
               // Report not found unless the match landed on this byte
               res_valid = 1'b1;
               restart   = 1'b1;
            end
         end
      end

      if (restart) begin
         cell_ctrl.clear = 1'b1;
         offset_in       = '0;
         cur_addr_in     = base_ff;
         count_in        = '0;
         done_in         = 1'b0;
      end

      // Keep base + offset in step with a new base
      if (csr_fire && (csr_index == CSR_BASE_ADDRESS)) begin
         cur_addr_in = csr_data + offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= LEN_W'(1);
         occ_ff     <= '0;
         base_ff    <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_PATTERN_BYTES:    pattern_ff <= csr_data;
            CSR_PATTERN_LENGTH:   length_ff  <= csr_data[LEN_W-1:0];
            CSR_OCCURRENCE_INDEX: occ_ff     <= csr_data[OCC_W-1:0];
            CSR_BASE_ADDRESS:     base_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         cur_addr_ff <= '0;
         count_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         offset_ff   <= offset_in;
         cur_addr_ff <= cur_addr_in;
         count_ff    <= count_in;
         done_ff     <= done_in;
      end
   end

   // Output queue: main register plus skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_found_in  = out_found_ff;
      out_addr_in   = out_addr_ff;
      skid_valid_in = skid_valid_ff;
      skid_found_in = skid_found_ff;
      skid_addr_in  = skid_addr_ff;
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_found_in  = skid_found_ff;
            out_addr_in   = skid_addr_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_found_in = res_found;
            out_addr_in  = res_addr;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_found_in = res_found;
         skid_addr_in  = res_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff  <= out_found_in;
      out_addr_ff   <= out_addr_in;
      skid_found_ff <= skid_found_in;
      skid_addr_ff  <= skid_addr_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_addr_ff;
   assign rsp_tuser  = out_found_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_addr_ff == '0))
      else $error("not-found transaction carries a non-zero address");

   a_restart_offset: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (offset_ff == '0) && !done_ff)
      else $error("search did not restart after the region's last byte");

   a_done_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && done_ff) |-> !res_valid)
      else $error("result produced after the match was reported");
`endif

endmodule

### verif/tb_nth_byte_pattern_search_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nth byte pattern search block: stream driver, result monitor, predictor.
module tb_nth_byte_pattern_search_top;
   import pbs_pkg::*;

   localparam int WINDOW_BYTES    = MAX_PATTERN_BYTES_DEFAULT;
   localparam int RANDOM_BYTES    = 1450;
   localparam int MATCH_RUN_BYTES = 48;
   localparam int DRAIN_HOLD      = 4;
   localparam int FINAL_HOLD      = 8;
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } feed_item_type;

   typedef struct {
      logic              found;
      logic [ADDR_W-1:0] address;
   } search_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata = '0;   // [7:0] data_byte
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [ADDR_W-1:0]      rsp_tdata;        // [63:0] match_address
   logic                   rsp_tuser;        // [0] found
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATTERN_BYTES;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor configuration copy
   logic [PATTERN_W-1:0] cfg_pattern    = '0;
   logic [LEN_W-1:0]     cfg_length     = 4'd1;
   logic [OCC_W-1:0]     cfg_occurrence = '0;
   logic [ADDR_W-1:0]    cfg_base       = '0;

   // Predictor search state
   logic [BYTE_W-1:0] window_bytes [WINDOW_BYTES];
   int unsigned       window_fill;
   logic [ADDR_W-1:0] region_offset;
   logic [OCC_W-1:0]  matches_seen;
   bit                search_done;

   feed_item_type     byte_feed [$];
   search_result_type search_results_due [$];
   int                bytes_outstanding = 0;
   int                mismatches = 0;
   int                quiet_cycles = 0;
   bit                calm = 1'b0;

   nth_byte_pattern_search_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void restart_search();
      int i;
      for (i = 0; i < WINDOW_BYTES; i++) window_bytes[i] = '0;
      window_fill   = 0;
      region_offset = '0;
      matches_seen  = '0;
      search_done   = 1'b0;
   endfunction

   // Clamp the configured length into 1..window size
   function automatic int unsigned used_length();
      int unsigned span;
      span = 32'(cfg_length);
      if (span == 0) span = 1;
      if (span > WINDOW_BYTES) span = WINDOW_BYTES;
      return span;
   endfunction

   function automatic void step_search(input logic [BYTE_W-1:0] data_byte,
                                       input logic last_byte);
      int                i;
      int unsigned       span;
      bit                hit;
      bit                emitted;
      search_result_type res;
      emitted = 1'b0;
      if (search_done) begin
         if (last_byte) restart_search();
         return;
      end
      for (i = WINDOW_BYTES - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
      window_bytes[0] = data_byte;
      if (window_fill < WINDOW_BYTES) window_fill++;
      span = used_length();
      // Oldest window byte lines up with the first pattern byte
      hit = (window_fill >= span);
      for (i = 0; i < span; i++) begin
         if (window_bytes[span - 1 - i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
         if (matches_seen == cfg_occurrence) begin
            res.found   = 1'b1;
            res.address = cfg_base + (region_offset - ADDR_W'(span - 1));
            search_results_due.push_back(res);
            emitted     = 1'b1;
            search_done = 1'b1;
         end else if (matches_seen != {OCC_W{1'b1}}) begin
            matches_seen++;
         end
      end
      region_offset++;
      if (last_byte) begin
         if (!emitted) begin
            res.found   = 1'b0;
            res.address = '0;
            search_results_due.push_back(res);
         end
         restart_search();
      end
   endfunction

   initial restart_search();

   // Request driver: present the next queued byte, hold while stalled
   always @(posedge clock) begin
      feed_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_search(req_tdata, req_tlast);
            bytes_outstanding--;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
               next_item = byte_feed.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.data;
               req_tlast  <= next_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      search_result_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (search_results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result found=%0b address=%h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               due = search_results_due.pop_front();
               if (rsp_tuser !== due.found)
                  report_mismatch($sformatf("found %0b, predicted %0b", rsp_tuser, due.found));
               if (rsp_tdata !== due.address)
                  report_mismatch($sformatf("address %h, predicted %h", rsp_tdata, due.address));
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 32);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Call just after posedge clock; leaves csr_valid high for a following write
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PATTERN_BYTES:    cfg_pattern    = value;
         CSR_PATTERN_LENGTH:   cfg_length     = value[LEN_W-1:0];
         CSR_OCCURRENCE_INDEX: cfg_occurrence = value[OCC_W-1:0];
         CSR_BASE_ADDRESS:     cfg_base       = value;
         default: ;
      endcase
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] data_byte, input logic last_byte);
      feed_item_type item;
      item.data = data_byte;
      item.last = last_byte;
      byte_feed.push_back(item);
      bytes_outstanding++;
   endtask

   // Wait for every byte and result, then hold for the pipeline to settle
   task automatic drain_and_hold();
      @(posedge clock);
      while (bytes_outstanding != 0 || search_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   // Mix whole and cut-short copies of the pattern with noise bytes
   task automatic queue_region(input int n_bytes, input bit close);
      int unsigned       span;
      int unsigned       cut;
      int                pos;
      int                k;
      logic [BYTE_W-1:0] b;
      span = used_length();
      pos  = 0;
      while (pos < n_bytes) begin
         if ($urandom_range(0, 99) < 45) begin
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
            for (k = 0; k < cut && pos < n_bytes; k++) begin
               push_byte(cfg_pattern[8*k +: 8], close && (pos == n_bytes - 1));
               pos++;
            end
         end else begin
            if ($urandom_range(0, 1)) b = BYTE_W'($urandom_range(0, 255));
            else                      b = cfg_pattern[8*$urandom_range(0, 7) +: 8];
            push_byte(b, close && (pos == n_bytes - 1));
            pos++;
         end
      end
   endtask

   initial begin
      int                    i;
      int                    phase;
      int                    regions;
      int                    n_bytes;
      int                    random_bytes;
      int                    r;
      logic [CSR_DATA_W-1:0] value;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pattern zero, one byte, first match, base zero
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      drain_and_hold();

      // Overlapping two-byte matches near the top of the address space
      write_register(CSR_PATTERN_BYTES,    64'hA5A5_A5A5_A5A5_A5A5);
      write_register(CSR_PATTERN_LENGTH,   64'd2);
      write_register(CSR_OCCURRENCE_INDEX, 64'd1);
      write_register(CSR_BASE_ADDRESS,     64'hFFFF_FFFF_FFFF_FFFE);
      csr_valid <= 1'b0;
      push_byte(8'hA5, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      drain_and_hold();

      // Full-width pattern found on the last byte
      write_register(CSR_PATTERN_BYTES,    64'h8877_6655_4433_2211);
      write_register(CSR_PATTERN_LENGTH,   64'd8);
      write_register(CSR_OCCURRENCE_INDEX, 64'd0);
      write_register(CSR_BASE_ADDRESS,     64'h0000_0000_0000_1000);
      csr_valid <= 1'b0;
      for (i = 0; i < 8; i++) push_byte(BYTE_W'(8'h11 * (i + 1)), i == 7);
      drain_and_hold();

      // Oversized length clamps to eight: seven bytes cannot match
      write_register(CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_valid <= 1'b0;
      for (i = 0; i < 7; i++) push_byte(BYTE_W'(8'h11 * (i + 1)), i == 6);
      drain_and_hold();

      // Zero length acts as one byte; requested match never arrives
      write_register(CSR_PATTERN_BYTES,    64'hFFFF_FFFF_FFFF_FFFF);
      write_register(CSR_PATTERN_LENGTH,   64'd0);
      write_register(CSR_OCCURRENCE_INDEX, 64'd3);
      csr_valid <= 1'b0;
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      drain_and_hold();

      // Settings changed mid-region apply to the bytes already held
      write_register(CSR_PATTERN_BYTES,    64'h0000_0000_0000_0033);
      write_register(CSR_PATTERN_LENGTH,   64'd1);
      write_register(CSR_OCCURRENCE_INDEX, 64'd0);
      csr_valid <= 1'b0;
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      drain_and_hold();
      write_register(CSR_PATTERN_BYTES,  64'h0000_0000_0000_3322);
      write_register(CSR_PATTERN_LENGTH, 64'd2);
      csr_valid <= 1'b0;
      push_byte(8'h33, 1'b1);
      drain_and_hold();

      // Highest occurrence number: a run of back-to-back matches stays below it
      calm = 1'b1;
      write_register(CSR_PATTERN_BYTES,    64'h0000_0000_0000_005A);
      write_register(CSR_PATTERN_LENGTH,   64'd1);
      write_register(CSR_OCCURRENCE_INDEX, 64'hFFFF);
      write_register(CSR_BASE_ADDRESS,     64'h0123_4567_89AB_CDEF);
      csr_valid <= 1'b0;
      for (i = 0; i < MATCH_RUN_BYTES; i++) push_byte(8'h5A, 1'b0);
      drain_and_hold();
      // Counter now sits past the lowered index and keeps counting
      write_register(CSR_OCCURRENCE_INDEX, 64'd0);
      csr_valid <= 1'b0;
      for (i = 0; i < 3; i++) push_byte(8'h5A, 1'b0);
      drain_and_hold();
      write_register(CSR_OCCURRENCE_INDEX, 64'hFFFF);
      csr_valid <= 1'b0;
      push_byte(8'h5A, 1'b0);
      push_byte(8'h00, 1'b1);
      drain_and_hold();
      calm = 1'b0;

      random_bytes = 0;
      phase        = 0;
      while (random_bytes < RANDOM_BYTES) begin
         calm = (phase >= 6 && phase < 12);
         if (phase == 0 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       value = '0;
               1:       value = '1;
               2, 3, 4: value = {8{8'hAB | (8'(($urandom_range(0, 1))) << 4)}}
                                 ^ {$urandom_range(0, 1) ? 32'h0 : 32'h6600_0066, 32'h0};
               default: value = {$urandom, $urandom};
            endcase
            write_register(CSR_PATTERN_BYTES, value);
         end
         if (phase == 0 || $urandom_range(0, 1)) begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0:       value[LEN_W-1:0] = 4'd0;
               1:       value[LEN_W-1:0] = 4'($urandom_range(9, 15));
               default: value[LEN_W-1:0] = 4'($urandom_range(1, 8));
            endcase
            write_register(CSR_PATTERN_LENGTH, value);
         end
         if (phase == 0 || $urandom_range(0, 1)) begin
            value = {$urandom, $urandom};
            case ($urandom_range(0, 19))
               0, 1:    value[OCC_W-1:0] = 16'hFFFF;
               2:       value[OCC_W-1:0] = 16'($urandom);
               3, 4, 5, 6, 7:
                        value[OCC_W-1:0] = 16'($urandom_range(3, 10));
               default: value[OCC_W-1:0] = 16'($urandom_range(0, 2));
            endcase
            write_register(CSR_OCCURRENCE_INDEX, value);
         end
         if (phase == 0 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0, 1:    value = '0;
               2:       value = '1;
               3, 4:    value = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
               default: value = {$urandom, $urandom};
            endcase
            write_register(CSR_BASE_ADDRESS, value);
         end
         csr_valid <= 1'b0;

         regions = $urandom_range(1, 4);
         for (r = 0; r < regions; r++) begin
            n_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
            // Now and then leave the last region open across the next settings
            queue_region(n_bytes, (r < regions - 1) || ($urandom_range(0, 4) != 0));
            random_bytes += n_bytes;
         end
         drain_and_hold();
         phase++;
      end

      // Close any region left open
      calm = 1'b0;
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      drain_and_hold();
      repeat (FINAL_HOLD) @(posedge clock);

      if (search_results_due.size() != 0)
         report_mismatch($sformatf("%0d predicted results never arrived",
                                   search_results_due.size()));
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
